/* hw/rtl/qsd_pkg.sv */
// Package for the signed Q16.16 divider: fixed-point format constants
// and the request and response structs between the top level and its core.
// Depends on nothing.
package qsd_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 32;
  // Shifted dividend magnitude with one spare leading bit.
  localparam int unsigned NumW     = DataW + FracBits + 1;
  localparam int unsigned StepW    = $clog2(DataW);

  localparam logic [DataW-1:0] PosSat = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] NegSat = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    logic              start;
    logic [NumW-1:0]   num;
    logic [DataW-1:0]  den;
  } core_req_t;

  typedef struct packed {
    logic              done;
    logic              big;
    logic [DataW-1:0]  quo;
  } core_rsp_t;

endpackage

/* hw/rtl/qsd_core.sv */
// Iterative unsigned restoring divider core of the signed Q16.16 divider.
// Uses qsd_pkg for widths and the request and response structs.
module qsd_core
  import qsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  core_req_t req_i,
  output core_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    C_IDLE,
    C_CHECK,
    C_DIV
  } core_state_e;

  core_state_e      state_q;
  logic [NumW-1:0]  num_q;
  logic [DataW-1:0] den_q;
  logic [DataW-1:0] rem_q;
  logic [StepW-1:0] cnt_q;
  logic             big_q;
  logic             done_q;

  logic [DataW-1:0] top_ext;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;
  logic             ge;

  assign top_ext = DataW'(num_q[NumW-1:DataW]);
  assign trial   = {rem_q, num_q[DataW-1]};
  assign diff    = trial - {1'b0, den_q};
  assign ge      = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
      big_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (req_i.start) begin
            num_q   <= req_i.num;
            den_q   <= req_i.den;
            big_q   <= 1'b0;
            state_q <= C_CHECK;
          end
        end
        C_CHECK: begin
          // Quotient of 2^32 or more shows up as top bits not below the divisor.
          if (top_ext >= den_q) begin
            big_q   <= 1'b1;
            done_q  <= 1'b1;
            state_q <= C_IDLE;
          end else begin
            rem_q   <= top_ext;
            cnt_q   <= '0;
            state_q <= C_DIV;
          end
        end
        C_DIV: begin
          rem_q            <= ge ? diff[DataW-1:0] : trial[DataW-1:0];
          num_q[DataW-1:0] <= {num_q[DataW-2:0], ge};
          cnt_q            <= cnt_q + 1'b1;
          if (cnt_q == StepW'(DataW - 1)) begin
            done_q  <= 1'b1;
            state_q <= C_IDLE;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.big  = big_q;
  assign rsp_o.quo  = num_q[DataW-1:0];

endmodule

/* hw/rtl/q16_signed_divider.sv */
// Top level of the signed Q16.16 divider: handshake, sign handling and saturation.
// Depends on qsd_pkg and instantiates qsd_core.
//
// This block divides two signed Q16.16 numbers and returns the quotient
// truncated toward zero, one result item for each input item. A zero divisor
// gives a quotient of 0 with divide_by_zero set; a quotient that does not fit
// in 32 bits saturates to the largest or smallest value with overflow set.
// An item goes from acceptance to a valid result in these steps: the core is
// loaded at the accepting edge, then come one overflow check and 32 steps of
// the shared restoring subtract-and-compare unit, the hand-back of the quotient
// to the top level, and the sign fix-up, which waits while the output register
// is full. A zero divisor skips the core and goes straight to the fix-up.
// The block takes a new item only while it is idle, so it cannot take the next
// item until the last one has reached the output register, and the last result
// may still be waiting in the output register at that time.
module q16_signed_divider
  import qsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] quotient_o,
  output logic             divide_by_zero_o,
  output logic             overflow_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WRAP
  } state_e;

  state_e           state_q;
  logic             neg_q;
  logic             dbz_q;
  logic             big_q;
  logic             out_valid_q;
  logic [DataW-1:0] quotient_q;
  logic             dbz_out_q;
  logic             ovf_out_q;

  logic             in_accept;
  logic             out_free;
  logic [DataW-1:0] mag_a;
  logic [DataW-1:0] mag_b;
  logic [DataW-1:0] quo_neg;
  core_req_t        req;
  core_rsp_t        rsp;

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Unsigned magnitudes: the most negative value maps to 2^31 exactly.
  assign mag_a = dividend_i[DataW-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign mag_b = divisor_i[DataW-1]  ? (~divisor_i + 1'b1)  : divisor_i;

  assign req.start = in_accept && (divisor_i != '0);
  assign req.num   = NumW'(mag_a) << FracBits;
  assign req.den   = mag_b;

  qsd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign quo_neg = ~rsp.quo + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      neg_q       <= 1'b0;
      dbz_q       <= 1'b0;
      big_q       <= 1'b0;
      quotient_q  <= '0;
      dbz_out_q   <= 1'b0;
      ovf_out_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            neg_q <= dividend_i[DataW-1] ^ divisor_i[DataW-1];
            dbz_q <= (divisor_i == '0);
            big_q <= 1'b0;
            // A zero divisor needs no division at all.
            state_q <= (divisor_i == '0) ? S_WRAP : S_RUN;
          end
        end
        S_RUN: begin
          if (rsp.done) begin
            // The core holds its quotient until the next start, so it is
            // still readable in the fix-up state.
            big_q   <= rsp.big;
            state_q <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            dbz_out_q   <= dbz_q;
            state_q     <= S_IDLE;
            if (dbz_q) begin
              quotient_q <= '0;
              ovf_out_q  <= 1'b0;
            end else if (neg_q) begin
              // Magnitude 2^31 with differing signs is exact.
              if (big_q || (rsp.quo > NegSat)) begin
                quotient_q <= NegSat;
                ovf_out_q  <= 1'b1;
              end else begin
                quotient_q <= quo_neg;
                ovf_out_q  <= 1'b0;
              end
            end else begin
              if (big_q || rsp.quo[DataW-1]) begin
                quotient_q <= PosSat;
                ovf_out_q  <= 1'b1;
              end else begin
                quotient_q <= rsp.quo;
                ovf_out_q  <= 1'b0;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign quotient_o       = quotient_q;
  assign divide_by_zero_o = dbz_out_q;
  assign overflow_o       = ovf_out_q;

endmodule

/* test/tb_q16_signed_divider.sv */
// Self-checking testbench for the signed Q16.16 divider q16_signed_divider.
// Depends on qsd_pkg for the data width, fraction width and saturation values.
`timescale 1ns / 100ps

module tb_q16_signed_divider;
  import qsd_pkg::*;

  // One result item of the divider, as the testbench predicts and compares it.
  typedef struct packed {
    logic [DataW-1:0] quotient;
    logic             div_zero;
    logic             ovf;
  } quo_result_t;

  // A row of the directed table. Rows marked Typed carry an expected result
  // that is written in by hand. Rows marked Predicted get theirs from the
  // predictor below.
  typedef struct packed {
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
    logic             known;
    quo_result_t      res;
  } dir_row_t;

  localparam logic Typed     = 1'b1;
  localparam logic Predicted = 1'b0;

  // DivLatency stands for the block's time from acceptance to result, and the
  // drain at the end waits longer. The cycle limit covers over 500 items, each
  // with the worst receiver stall and the long hold-off, several times over.
  localparam int unsigned DivLatency   = 35;
  localparam int unsigned DrainCycles  = 2 * DivLatency;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned PhaseItems   = 170;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned NumDirected  = 23;

  localparam dir_row_t DirTable [NumDirected] = '{
    // A zero divisor gives 0 with divide_by_zero set, whatever the dividend is.
    '{32'h0001_0000, 32'h0000_0000, Typed, '{32'h0000_0000, 1'b1, 1'b0}},
    '{32'h8000_0000, 32'h0000_0000, Typed, '{32'h0000_0000, 1'b1, 1'b0}},
    '{32'h0000_0000, 32'h0000_0000, Typed, '{32'h0000_0000, 1'b1, 1'b0}},
    // A zero dividend, also with differing signs: the negation of zero is zero.
    '{32'h0000_0000, 32'h0001_0000, Typed, '{32'h0000_0000, 1'b0, 1'b0}},
    '{32'h0000_0000, 32'hFFFF_0000, Typed, '{32'h0000_0000, 1'b0, 1'b0}},
    // The extreme dividends divided by plus one and minus one.
    '{32'h7FFF_FFFF, 32'h0001_0000, Typed, '{32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{32'h8000_0000, 32'h0001_0000, Typed, '{32'h8000_0000, 1'b0, 1'b0}},
    '{32'h8000_0000, 32'hFFFF_0000, Typed, '{PosSat,        1'b0, 1'b1}},
    // The tiniest divisors force saturation in both directions.
    '{32'h7FFF_FFFF, 32'h0000_0001, Typed, '{PosSat,        1'b0, 1'b1}},
    '{32'h7FFF_FFFF, 32'hFFFF_FFFF, Typed, '{NegSat,        1'b0, 1'b1}},
    '{32'h8000_0000, 32'h0000_0001, Typed, '{NegSat,        1'b0, 1'b1}},
    // The most negative divisor has the magnitude 2^31 as well.
    '{32'h8000_0000, 32'h8000_0000, Typed, '{32'h0001_0000, 1'b0, 1'b0}},
    // Quotients that truncate to zero, and one that is exactly one.
    '{32'h0000_0001, 32'h7FFF_FFFF, Typed, '{32'h0000_0000, 1'b0, 1'b0}},
    '{32'hFFFF_FFFF, 32'h7FFF_FFFF, Typed, '{32'h0000_0000, 1'b0, 1'b0}},
    '{32'h0001_0000, 32'h0001_0000, Typed, '{32'h0001_0000, 1'b0, 1'b0}},
    // The overflow boundary. A magnitude of 2^31 saturates with equal signs.
    // With differing signs it is exact. One step beyond it saturates.
    '{32'h0000_7FFF, 32'h0000_0001, Typed, '{32'h7FFF_0000, 1'b0, 1'b0}},
    '{32'h0000_8000, 32'h0000_0001, Typed, '{PosSat,        1'b0, 1'b1}},
    '{32'hFFFF_8000, 32'h0000_0001, Typed, '{32'h8000_0000, 1'b0, 1'b0}},
    '{32'hFFFF_7FFF, 32'h0000_0001, Typed, '{NegSat,        1'b0, 1'b1}},
    // Ordinary values, checked against the predictor.
    '{32'h0003_0000, 32'h0002_0000, Predicted, '{32'h0, 1'b0, 1'b0}},
    '{32'hFFFD_0000, 32'h0002_0000, Predicted, '{32'h0, 1'b0, 1'b0}},
    '{32'h1234_5678, 32'h0003_1415, Predicted, '{32'h0, 1'b0, 1'b0}},
    '{32'hDEAD_BEEF, 32'hCAFE_F00D, Predicted, '{32'h0, 1'b0, 1'b0}}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [DataW-1:0] dividend_i;
  logic [DataW-1:0] divisor_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [DataW-1:0] quotient_o;
  logic             divide_by_zero_o;
  logic             overflow_o;

  // The expected result of the item on offer. It is pushed at acceptance.
  quo_result_t offer_quo;
  quo_result_t pending_quo_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned err_count;

  q16_signed_divider u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .dividend_i       (dividend_i),
    .divisor_i        (divisor_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .quotient_o       (quotient_o),
    .divide_by_zero_o (divide_by_zero_o),
    .overflow_o       (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Predicted signed fixed-point division. Both operands turn into 33-bit
  // magnitudes, so that -2^31 keeps the magnitude 2^31. The magnitude of the
  // dividend is shifted up by the fraction width and divided without rounding.
  // The sign is then restored, saturating when the quotient does not fit.
  function automatic quo_result_t divide_q16(logic [DataW-1:0] a, logic [DataW-1:0] b);
    logic [DataW:0] mag_a;
    logic [DataW:0] mag_b;
    logic [63:0]    mag_q;
    quo_result_t    r;
    r = '{quotient: '0, div_zero: 1'b0, ovf: 1'b0};
    if (b == '0) begin
      r.div_zero = 1'b1;
    end else begin
      mag_a = a[DataW-1] ? (33'h1_0000_0000 - {1'b0, a}) : {1'b0, a};
      mag_b = b[DataW-1] ? (33'h1_0000_0000 - {1'b0, b}) : {1'b0, b};
      mag_q = ({31'b0, mag_a} << FracBits) / {31'b0, mag_b};
      if (a[DataW-1] ^ b[DataW-1]) begin
        // A magnitude of exactly 2^31 is the most negative value and is exact.
        if (mag_q > 64'h8000_0000) begin
          r.quotient = NegSat;
          r.ovf      = 1'b1;
        end else begin
          r.quotient = 32'(64'h1_0000_0000 - mag_q);
        end
      end else if (mag_q > 64'h7FFF_FFFF) begin
        r.quotient = PosSat;
        r.ovf      = 1'b1;
      end else begin
        r.quotient = mag_q[DataW-1:0];
      end
    end
    return r;
  endfunction

  // A random operand. It mixes full-range words, small and scaled magnitudes of
  // either sign, single bits and the extreme values, so that saturation and
  // tiny quotients both come up often.
  function automatic logic [DataW-1:0] rand_operand();
    logic [DataW-1:0] w;
    case ($urandom_range(5))
      0, 1: begin
        w = $urandom;
      end
      2: begin
        w = $urandom >> $urandom_range(31);
      end
      3: begin
        w = $urandom_range(65535);
      end
      4: begin
        w = 32'h1 << $urandom_range(31);
      end
      default: begin
        case ($urandom_range(6))
          0:       w = 32'h0000_0000;
          1:       w = 32'h0000_0001;
          2:       w = 32'h7FFF_FFFF;
          3:       w = 32'h8000_0000;
          4:       w = 32'h0001_0000;
          5:       w = 32'hFFFF_0000;
          default: w = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    if ($urandom_range(1) == 1) begin
      w = -w;
    end
    return w;
  endfunction

  // Offers one item at a falling edge and waits for the rising edge that takes
  // it. The sender may idle first, for a random stretch. Valid stays high between
  // back-to-back items, so it is assigned only once in each time step.
  task automatic offer_item(logic [DataW-1:0] a, logic [DataW-1:0] b, quo_result_t exp_quo);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    dividend_i <= a;
    divisor_i  <= b;
    offer_quo  <= exp_quo;
    do begin
      @(posedge clk_i);
    end while (!in_valid_i || in_stall_o);
  endtask

  // Changes the idle rates between phases. Valid drops at a falling edge.
  // The rates and the hold-off change at a rising edge, so the receiver
  // process never reads them in the same time step as they are written.
  task automatic set_phase(int unsigned send_pct, int unsigned recv_pct, int unsigned hold);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    hold_left     = hold;
  endtask

  task automatic run_random_items(int unsigned count);
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    for (int unsigned n = 0; n < count; n++) begin
      a = rand_operand();
      // About one divisor in twenty is zero.
      b = ($urandom_range(19) == 0) ? '0 : rand_operand();
      offer_item(a, b, divide_q16(a, b));
    end
  endtask

  // The receiver stalls at random. During a hold-off it stalls for a whole
  // stretch, so that the output register fills up and the block stalls its
  // input. The stretch is counted down here, once per cycle.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left    = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Both handshakes are sampled at the rising edge. An accepted input item
  // queues its expected result. An accepted result item is compared with the
  // oldest expectation.
  always @(posedge clk_i) begin
    quo_result_t got_quo;
    quo_result_t exp_quo;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pending_quo_q.push_back(offer_quo);
      end
      if (out_valid_o && !out_stall_i) begin
        got_quo = '{quotient: quotient_o, div_zero: divide_by_zero_o, ovf: overflow_o};
        if (pending_quo_q.size() == 0) begin
          err_count++;
          $display("%0t: result item with none expected: quotient %h dbz %b ovf %b",
                   $time, got_quo.quotient, got_quo.div_zero, got_quo.ovf);
        end else begin
          exp_quo = pending_quo_q.pop_front();
          if (got_quo.quotient !== exp_quo.quotient || got_quo.div_zero !== exp_quo.div_zero ||
              got_quo.ovf !== exp_quo.ovf) begin
            err_count++;
            $display("%0t: mismatch: expected quotient %h dbz %b ovf %b, got quotient %h dbz %b ovf %b",
                     $time, exp_quo.quotient, exp_quo.div_zero, exp_quo.ovf,
                     got_quo.quotient, got_quo.div_zero, got_quo.ovf);
          end
        end
      end
    end
  end

  // The watchdog ends a run that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    // Every input is known from time zero. Reset is held low at first, then released.
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    dividend_i    = '0;
    divisor_i     = '0;
    offer_quo     = '0;
    out_stall_i   = 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 84;
    hold_left     = 0;
    cycle_count   = 0;
    err_count     = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // The directed table runs with the rates of the first phase. Typed rows
    // carry their own expectation; the rest go through the predictor.
    foreach (DirTable[i]) begin
      offer_item(DirTable[i].dividend, DirTable[i].divisor,
                 DirTable[i].known ? DirTable[i].res
                                   : divide_q16(DirTable[i].dividend, DirTable[i].divisor));
    end
    run_random_items(PhaseItems);

    set_phase(84, 13, 0);
    run_random_items(PhaseItems);

    // The last phase opens with a long hold-off of the receiver, while the
    // sender keeps offering items without a gap.
    set_phase(0, 0, HoldCycles);
    run_random_items(PhaseItems);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_quo_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (err_count == 0 && pending_quo_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
